// ===== design/doubly_linked_list_engine_unit_macros.svh =====
// Assertion helpers for the RTL files.
`ifndef DOUBLY_LINKED_LIST_ENGINE_UNIT_MACROS_SVH
`define DOUBLY_LINKED_LIST_ENGINE_UNIT_MACROS_SVH

// expr must hold at every clock edge outside reset
`define DLLE_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// cons must hold in the cycle after ante
`define DLLE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/dlle_pkg.sv =====
`default_nettype none

package dlle_pkg;

   localparam int CAPACITY_DEF = 32;
   localparam int VALUE_W      = 32;

   typedef enum logic [1:0] {
      OP_INS_FRONT = 2'd0,
      OP_INS_BACK  = 2'd1,
      OP_DELETE    = 2'd2,
      OP_READ_ALL  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_EMPTY     = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_NODE,
      ST_INS_LINK,
      ST_DEL_WALK,
      ST_RO_WALK,
      ST_RESP
   } state_type;

endpackage

`default_nettype wire

// ===== design/dlle_ram.sv =====
`default_nettype none

module dlle_ram #(
   parameter int WIDTH = dlle_pkg::VALUE_W,
   parameter int DEPTH = dlle_pkg::CAPACITY_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // read data holds while rd_en is low
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/doubly_linked_list_engine_unit.sv =====
// Doubly linked list engine.
// Request channel (req_valid / req_stall): req_operation selects insert at front,
// insert at back, delete first match or read out all; req_item_value is the value.
// Response channel (rsp_valid / rsp_stall): rsp_status, rsp_out_value, rsp_last.
// Every request gives one response, except a read out of a non-empty list, which
// gives one response per node from head to tail with rsp_last on the final one.
// Requests are taken one at a time; req_stall is high while one is in progress.
// Insert writes the new node, then links it to the old end node; the first
// node needs no link step, and a full list goes straight to the response, as
// does an empty list for delete or read out. Delete walks from the head.
// The walks are paced by the node store: one synchronous read per linked node.
// While rsp_stall is high the output register holds and the read out walk pauses; the
// next request is taken while the last response still waits in the register.
// Synchronous reset empties the list and marks every node free; no memory clearing is
// needed, since links only reach entries that were written.
`default_nettype none

`include "doubly_linked_list_engine_unit_macros.svh"

module doubly_linked_list_engine_unit #(
   parameter int CAPACITY = dlle_pkg::CAPACITY_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_operation,
   input  logic signed [dlle_pkg::VALUE_W-1:0]  req_item_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [1:0]                           rsp_status,
   output logic signed [dlle_pkg::VALUE_W-1:0]  rsp_out_value,
   output logic                                 rsp_last
);

   localparam int IW = $clog2(CAPACITY + 1);
   localparam int AW = $clog2(CAPACITY);
   localparam int VW = dlle_pkg::VALUE_W;
   localparam logic [IW-1:0] NONE_IX   = IW'(CAPACITY);
   localparam logic [IW-1:0] LAST_STEP = IW'(CAPACITY - 1);

   dlle_pkg::state_type  state_ff, state_in;
   dlle_pkg::op_type     op_ff, op_in;
   dlle_pkg::status_type status_ff, status_in;
   logic signed [VW-1:0] val_ff, val_in;
   logic [IW-1:0]        n_ff, n_in;
   logic [IW-1:0]        cur_ff, cur_in;
   logic [IW-1:0]        steps_ff, steps_in;
   logic [IW-1:0]        head_ff, head_in;
   logic [IW-1:0]        tail_ff, tail_in;
   logic [IW-1:0]        count_ff, count_in;
   logic [CAPACITY-1:0]  free_ff, free_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   dlle_pkg::status_type rsp_status_ff, rsp_status_in;
   logic signed [VW-1:0] rsp_value_ff, rsp_value_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic [IW-1:0] free_ix;
   logic          list_empty, list_full, out_free, match, walk_end;

   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [VW-1:0] val_rd;
   logic [IW-1:0] next_rd, prev_rd;
   logic          val_we, next_we, prev_we;
   logic [AW-1:0] val_wa, next_wa, prev_wa;
   logic [IW-1:0] next_wd, prev_wd;

   // lowest-numbered free node
   always_comb begin
      free_ix = NONE_IX;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (free_ff[i]) begin
            free_ix = IW'(i);
         end
      end
   end

   assign list_empty = (head_ff >= NONE_IX);
   assign list_full  = (free_ff == '0);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign match      = (val_rd == val_ff);
   assign walk_end   = (next_rd >= NONE_IX) || (steps_ff == LAST_STEP);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      status_in     = status_ff;
      val_in        = val_ff;
      n_in          = n_ff;
      cur_in        = cur_ff;
      steps_in      = steps_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      free_in       = free_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;
      rd_en         = 1'b0;
      rd_addr       = head_ff[AW-1:0];
      val_we        = 1'b0;
      next_we       = 1'b0;
      prev_we       = 1'b0;
      val_wa        = n_ff[AW-1:0];
      next_wa       = n_ff[AW-1:0];
      prev_wa       = n_ff[AW-1:0];
      next_wd       = NONE_IX;
      prev_wd       = NONE_IX;

      case (state_ff)
         dlle_pkg::ST_IDLE: begin
            if (req_valid) begin
               op_in    = dlle_pkg::op_type'(req_operation);
               val_in   = req_item_value;
               n_in     = free_ix;
               cur_in   = head_ff;
               steps_in = '0;
               case (dlle_pkg::op_type'(req_operation))
                  dlle_pkg::OP_INS_FRONT, dlle_pkg::OP_INS_BACK: begin
                     if (list_full) begin
                        status_in = dlle_pkg::STATUS_FULL;
                        state_in  = dlle_pkg::ST_RESP;
                     end else begin
                        state_in = dlle_pkg::ST_INS_NODE;
                     end
                  end
                  dlle_pkg::OP_DELETE: begin
                     if (list_empty) begin
                        status_in = dlle_pkg::STATUS_EMPTY;
                        state_in  = dlle_pkg::ST_RESP;
                     end else begin
                        rd_en    = 1'b1;
                        state_in = dlle_pkg::ST_DEL_WALK;
                     end
                  end
                  dlle_pkg::OP_READ_ALL: begin
                     val_in = '0;
                     if (list_empty) begin
                        status_in = dlle_pkg::STATUS_EMPTY;
                        state_in  = dlle_pkg::ST_RESP;
                     end else begin
                        rd_en    = 1'b1;
                        state_in = dlle_pkg::ST_RO_WALK;
                     end
                  end
                  default: begin
                     state_in = dlle_pkg::ST_IDLE;
                  end
               endcase
            end
         end

         dlle_pkg::ST_INS_NODE: begin
            val_we  = 1'b1;
            next_we = 1'b1;
            prev_we = 1'b1;
            next_wd = (list_empty || op_ff == dlle_pkg::OP_INS_BACK) ? NONE_IX : head_ff;
            prev_wd = (list_empty || op_ff == dlle_pkg::OP_INS_FRONT) ? NONE_IX : tail_ff;
            free_in[n_ff[AW-1:0]] = 1'b0;
            count_in  = count_ff + 1'b1;
            status_in = dlle_pkg::STATUS_OK;
            if (list_empty) begin
               head_in  = n_ff;
               tail_in  = n_ff;
               state_in = dlle_pkg::ST_RESP;
            end else begin
               state_in = dlle_pkg::ST_INS_LINK;
            end
         end

         // second link write of a non-empty insert goes to the old end node
         dlle_pkg::ST_INS_LINK: begin
            if (op_ff == dlle_pkg::OP_INS_FRONT) begin
               prev_we = 1'b1;
               prev_wa = head_ff[AW-1:0];
               prev_wd = n_ff;
               head_in = n_ff;
            end else begin
               next_we = 1'b1;
               next_wa = tail_ff[AW-1:0];
               next_wd = n_ff;
               tail_in = n_ff;
            end
            state_in = dlle_pkg::ST_RESP;
         end

         // RAM outputs hold node cur_ff
         dlle_pkg::ST_DEL_WALK: begin
            if (match) begin
               if (prev_rd < NONE_IX) begin
                  next_we = 1'b1;
                  next_wa = prev_rd[AW-1:0];
                  next_wd = next_rd;
               end else begin
                  head_in = next_rd;
               end
               if (next_rd < NONE_IX) begin
                  prev_we = 1'b1;
                  prev_wa = next_rd[AW-1:0];
                  prev_wd = prev_rd;
               end else begin
                  tail_in = prev_rd;
               end
               free_in[cur_ff[AW-1:0]] = 1'b1;
               if (count_ff != '0) begin
                  count_in = count_ff - 1'b1;
               end
               status_in = dlle_pkg::STATUS_OK;
               state_in  = dlle_pkg::ST_RESP;
            end else if (walk_end) begin
               status_in = dlle_pkg::STATUS_NOT_FOUND;
               state_in  = dlle_pkg::ST_RESP;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = next_rd[AW-1:0];
               cur_in   = next_rd;
               steps_in = steps_ff + 1'b1;
            end
         end

         dlle_pkg::ST_RO_WALK: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = dlle_pkg::STATUS_OK;
               rsp_value_in  = val_rd;
               rsp_last_in   = walk_end;
               if (walk_end) begin
                  state_in = dlle_pkg::ST_IDLE;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = next_rd[AW-1:0];
                  cur_in   = next_rd;
                  steps_in = steps_ff + 1'b1;
               end
            end
         end

         dlle_pkg::ST_RESP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_value_in  = val_ff;
               rsp_last_in   = 1'b1;
               state_in      = dlle_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = dlle_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dlle_pkg::ST_IDLE;
         head_ff      <= NONE_IX;
         tail_ff      <= NONE_IX;
         free_ff      <= '1;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         free_ff      <= free_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      status_ff     <= status_in;
      val_ff        <= val_in;
      n_ff          <= n_in;
      cur_ff        <= cur_in;
      steps_ff      <= steps_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
   end

   dlle_ram #(.WIDTH(VW), .DEPTH(CAPACITY)) u_value_ram (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (val_wa),
      .wr_data (val_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (val_rd)
   );

   dlle_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_next_ram (
      .clock   (clock),
      .wr_en   (next_we),
      .wr_addr (next_wa),
      .wr_data (next_wd),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (next_rd)
   );

   dlle_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_prev_ram (
      .clock   (clock),
      .wr_en   (prev_we),
      .wr_addr (prev_wa),
      .wr_data (prev_wd),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (prev_rd)
   );

   assign req_stall     = (state_ff != dlle_pkg::ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_last      = rsp_last_ff;

   `DLLE_ASSERT_ALWAYS(a_count_vs_empty, clock, reset, (count_ff == '0) == (head_ff == NONE_IX), "entry count disagrees with head pointer")
   `DLLE_ASSERT_ALWAYS(a_head_tail_none, clock, reset, (head_ff == NONE_IX) == (tail_ff == NONE_IX), "head and tail disagree on empty list")
   `DLLE_ASSERT_ALWAYS(a_free_count, clock, reset, ($countones(free_ff) + count_ff) == CAPACITY, "free map and entry count out of step")
   `DLLE_ASSERT_ALWAYS(a_no_rd_wr_overlap, clock, reset, !(rd_en && (val_we || next_we || prev_we)), "node store read and write in the same cycle")
   `DLLE_ASSERT_NEXT(a_insert_takes_node, clock, reset, state_ff == dlle_pkg::ST_INS_NODE, ($countones(free_ff) + 1) == $countones($past(free_ff)), "insert did not take exactly one free node")

endmodule

`default_nettype wire
